[hdl/rwc_pkg.sv]
`default_nettype none

package rwc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BLOCK_SHIFT  = 2'd0,
        CFG_WINDOW_COUNT = 2'd1,
        CFG_SUM_WIDTH    = 2'd2
    } t_cfg_index;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    // Register values after reset.
    localparam logic [3:0] BLOCK_SHIFT_RST  = 4'd10;
    localparam logic [1:0] WINDOW_COUNT_RST = 2'd1;
    localparam logic [2:0] SUM_WIDTH_RST    = 3'd4;

    // Masks applied to sum a, chosen by the checksum width.
    localparam logic [2:0]  SUM_WIDTH_NARROW = 3'd3;
    localparam logic [15:0] MASK_A_NONE      = 16'h0000;
    localparam logic [15:0] MASK_A_BYTE      = 16'h00ff;
    localparam logic [15:0] MASK_A_FULL      = 16'hffff;

endpackage

`default_nettype wire

[hdl/rolling_window_checksum.sv]
`default_nettype none

// Rolling weak checksum over a byte stream. One byte is accepted per clock
// cycle while the output is not stalled, and each byte gives one output
// transaction, carrying the sums of the newest window (the last 2^block_shift
// bytes) and, when two windows are tracked, of the window just before it. The
// byte history sits in a single memory with one write port and two read
// ports; the two bytes that leave the windows are read in the cycle the byte
// is accepted, and the rolling stage rolls the sums and writes the running
// sums and the output register together. The sustained rate is one byte per
// cycle while the output is not stalled. There is no clearing pass after reset:
// bytes that have not entered since a restart are hidden by the fill count.
// Configuration registers must only be written while no bytes are in flight.
module rolling_window_checksum
    import rwc_pkg::*;
#(
    parameter int MAX_BLOCK_SHIFT = 12,
    parameter int HISTORY_DEPTH   = 8192
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Configuration write channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    // Byte input channel
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire [7:0]              i_data_byte,
    input  wire                    i_restart,
    // Checksum output channel
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [15:0]            o_newest_a,
    output logic [15:0]            o_newest_b,
    output logic [15:0]            o_prior_a,
    output logic [15:0]            o_prior_b,
    output logic                   o_window_full
);

    localparam int AW       = $clog2(HISTORY_DEPTH);
    localparam int FILL_MAX = 2 ** (MAX_BLOCK_SHIFT + 1);
    localparam int FW       = $clog2(FILL_MAX + 1);
    localparam int CW       = ((FW > AW) ? FW : AW) + 1;
    localparam int SW       = $clog2(MAX_BLOCK_SHIFT + 2);

    typedef struct packed {
        logic [7:0]    data;
        logic          restart;
        logic [SW-1:0] shift;
        logic          two;
        logic          newest_hit;
        logic          prior_hit;
        logic          full;
    } t_stage;

    // Configuration registers
    logic [3:0] r_block_shift;
    logic [1:0] r_window_count;
    logic [2:0] r_sum_width;

    // Byte history and stream position
    logic [7:0]    r_hist [HISTORY_DEPTH];
    logic [7:0]    r_rd_newest;
    logic [7:0]    r_rd_prior;
    logic [AW-1:0] r_wp;
    logic [AW-1:0] n_wp;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;

    // Rolling stage and running sums
    logic   r_s1_valid;
    t_stage r_s1;
    t_stage n_s1;
    logic [15:0] r_newest_a;
    logic [15:0] r_newest_b;
    logic [15:0] r_prior_a;
    logic [15:0] r_prior_b;
    logic [15:0] n_newest_a;
    logic [15:0] n_newest_b;
    logic [15:0] n_prior_a;
    logic [15:0] n_prior_b;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_newest_a;
    logic [15:0] r_out_newest_b;
    logic [15:0] r_out_prior_a;
    logic [15:0] r_out_prior_b;
    logic        r_out_full;

    logic          s1_adv;
    logic          in_acc;
    logic [SW-1:0] shift_eff;
    logic [CW-1:0] len_newest;
    logic [CW-1:0] len_prior;
    logic [CW-1:0] wp_ext;
    logic [CW-1:0] idx_newest;
    logic [CW-1:0] idx_prior;
    logic [FW-1:0] fill_base;
    logic [CW-1:0] need;
    logic [15:0]   mask_a;
    logic [7:0]    leave_newest;
    logic [7:0]    leave_prior;
    logic [31:0]   shl_newest;
    logic [31:0]   shl_prior;
    logic [15:0]   base_newest_a;
    logic [15:0]   base_newest_b;
    logic [15:0]   base_prior_a;
    logic [15:0]   base_prior_b;
    logic [15:0]   roll_prior_a;

    // Handshakes: the rolling stage moves whenever the output register frees.
    assign o_cfg_ready = 1'b1;
    assign s1_adv      = !r_out_valid || i_ready;
    assign o_ready     = !r_s1_valid || s1_adv;
    assign in_acc      = i_valid && o_ready;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_shift  <= BLOCK_SHIFT_RST;
            r_window_count <= WINDOW_COUNT_RST;
            r_sum_width    <= SUM_WIDTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BLOCK_SHIFT:  r_block_shift  <= i_cfg_data[3:0];
                CFG_WINDOW_COUNT: r_window_count <= i_cfg_data[1:0];
                CFG_SUM_WIDTH:    r_sum_width    <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Window lengths, read addresses and fill bookkeeping for the new byte.
    always_comb begin
        if (int'(r_block_shift) > MAX_BLOCK_SHIFT) begin
            shift_eff = SW'(MAX_BLOCK_SHIFT);
        end else begin
            shift_eff = SW'(r_block_shift);
        end
        len_newest = CW'(1) << shift_eff;
        len_prior  = len_newest << 1;
        wp_ext     = CW'(r_wp);
        fill_base  = i_restart ? '0 : r_fill;

        if (wp_ext >= len_newest) begin
            idx_newest = wp_ext - len_newest;
        end else begin
            idx_newest = wp_ext + CW'(HISTORY_DEPTH) - len_newest;
        end
        if (wp_ext >= len_prior) begin
            idx_prior = wp_ext - len_prior;
        end else begin
            idx_prior = wp_ext + CW'(HISTORY_DEPTH) - len_prior;
        end

        if (fill_base < FW'(FILL_MAX)) begin
            n_fill = fill_base + FW'(1);
        end else begin
            n_fill = fill_base;
        end
        n_wp = (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);

        n_s1.data       = i_data_byte;
        n_s1.restart    = i_restart;
        n_s1.shift      = shift_eff;
        n_s1.two        = (r_window_count >= 2'd2);
        n_s1.newest_hit = (len_newest <= CW'(HISTORY_DEPTH))
                       && (len_newest <= CW'(fill_base));
        n_s1.prior_hit  = (len_prior <= CW'(HISTORY_DEPTH))
                       && (len_prior <= CW'(fill_base));
        need            = n_s1.two ? len_prior : len_newest;
        n_s1.full       = (CW'(n_fill) >= need);
    end

    // History memory: write the new byte, read the two leaving bytes.
    // The read returns the old contents when it meets the write address.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hist[r_wp] <= i_data_byte;
            r_rd_newest  <= r_hist[AW'(idx_newest)];
            r_rd_prior   <= r_hist[AW'(idx_prior)];
        end
    end

    // Stream position and the rolling stage's control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (in_acc) begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // Roll both windows; a restart starts from all-zero sums.
    always_comb begin
        base_newest_a = r_s1.restart ? 16'h0000 : r_newest_a;
        base_newest_b = r_s1.restart ? 16'h0000 : r_newest_b;
        base_prior_a  = r_s1.restart ? 16'h0000 : r_prior_a;
        base_prior_b  = r_s1.restart ? 16'h0000 : r_prior_b;
        leave_newest  = r_s1.newest_hit ? r_rd_newest : 8'h00;
        leave_prior   = (r_s1.two && r_s1.prior_hit) ? r_rd_prior : 8'h00;
        shl_newest    = 32'(leave_newest) << r_s1.shift;
        shl_prior     = 32'(leave_prior) << r_s1.shift;

        n_newest_a   = base_newest_a + 16'(r_s1.data) - 16'(leave_newest);
        n_newest_b   = base_newest_b + n_newest_a - shl_newest[15:0];
        roll_prior_a = base_prior_a + 16'(leave_newest) - 16'(leave_prior);
        if (r_s1.two) begin
            n_prior_a = roll_prior_a;
            n_prior_b = base_prior_b + roll_prior_a - shl_prior[15:0];
        end else begin
            n_prior_a = base_prior_a;
            n_prior_b = base_prior_b;
        end

        if (r_sum_width < SUM_WIDTH_NARROW) begin
            mask_a = MASK_A_NONE;
        end else if (r_sum_width == SUM_WIDTH_NARROW) begin
            mask_a = MASK_A_BYTE;
        end else begin
            mask_a = MASK_A_FULL;
        end
    end

    // Running sums, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest_a <= '0;
            r_newest_b <= '0;
            r_prior_a  <= '0;
            r_prior_b  <= '0;
        end else if (r_s1_valid && s1_adv) begin
            r_newest_a <= n_newest_a;
            r_newest_b <= n_newest_b;
            r_prior_a  <= n_prior_a;
            r_prior_b  <= n_prior_b;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_newest_a <= n_newest_a & mask_a;
            r_out_newest_b <= n_newest_b;
            r_out_prior_a  <= r_s1.two ? (n_prior_a & mask_a) : 16'h0000;
            r_out_prior_b  <= r_s1.two ? n_prior_b : 16'h0000;
            r_out_full     <= r_s1.full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_newest_a    = r_out_newest_a;
    assign o_newest_b    = r_out_newest_b;
    assign o_prior_a     = r_out_prior_a;
    assign o_prior_b     = r_out_prior_b;
    assign o_window_full = r_out_full;

    // A stalled rolling stage keeps its transaction and its read data.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1)
                                     && $stable(r_rd_newest) && $stable(r_rd_prior)))
        else $error("rolling stage lost its transaction while stalled");

    // A restart byte leaves exactly one byte counted.
    a_restart_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_restart) |=> (r_fill == FW'(1)))
        else $error("fill count wrong after restart");

    // The write pointer holds while no byte is taken.
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_wp))
        else $error("write pointer moved without a byte");

endmodule

`default_nettype wire

[verif/rwc_checker.sv]
`timescale 1ns / 100ps

// Watches the configuration, byte and checksum channels of the rolling
// checksum block, keeps its own copy of the byte history and window sums,
// and compares every checksum transaction against the oldest prediction.
module rwc_checker
    import rwc_pkg::*;
#(
    parameter int MAX_BLOCK_SHIFT = 12,
    parameter int HISTORY_DEPTH   = 8192
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    input  wire                    i_cfg_ready,
    input  wire [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                    i_in_valid,
    input  wire                    i_in_ready,
    input  wire [7:0]              i_data_byte,
    input  wire                    i_restart,
    input  wire                    i_out_valid,
    input  wire                    i_out_ready,
    input  wire [15:0]             i_newest_a,
    input  wire [15:0]             i_newest_b,
    input  wire [15:0]             i_prior_a,
    input  wire [15:0]             i_prior_b,
    input  wire                    i_window_full,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    // The fill count saturates at two windows of the largest size.
    localparam int FILL_LIMIT = 2 << MAX_BLOCK_SHIFT;

    typedef struct packed {
        logic [15:0] newest_a;
        logic [15:0] newest_b;
        logic [15:0] prior_a;
        logic [15:0] prior_b;
        logic        window_full;
    } t_checksum;

    t_checksum   expected_sums[$];
    logic [7:0]  byte_log[HISTORY_DEPTH];
    int unsigned log_slot;
    int unsigned fill_level;
    logic [15:0] newest_a_sum;
    logic [15:0] newest_b_sum;
    logic [15:0] prior_a_sum;
    logic [15:0] prior_b_sum;
    logic [3:0]  block_shift;
    logic [1:0]  window_count;
    logic [2:0]  sum_width;
    int          mismatch_count = 0;
    int          results_seen = 0;

    assign o_fail_count = mismatch_count;
    assign o_checked    = results_seen;

    // One line per mismatch, and a count the testbench top turns into the verdict.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s on checksum transaction %0d: got 0x%0h, expected 0x%0h",
                                      name, results_seen, got, want));
    endtask

    // The byte that entered back bytes ago; bytes not held since the restart read as zero.
    function automatic logic [7:0] history_byte(input int unsigned back);
        int unsigned slot;
        if (back == 0 || back > HISTORY_DEPTH || back > fill_level)
            return 8'h00;
        slot = (log_slot + HISTORY_DEPTH - back) % HISTORY_DEPTH;
        return byte_log[slot];
    endfunction

    // Roll one window by one byte: a gains the entering byte and loses the leaving
    // one, b gains the new a and loses the leaving byte weighted by the window length.
    task automatic roll_sums(inout logic [15:0] sum_a, inout logic [15:0] sum_b,
                             input logic [7:0] enter, input logic [7:0] leave,
                             input int unsigned shift);
        logic [15:0] leave_weighted;
        leave_weighted = 16'({24'd0, leave} << shift);
        sum_a = sum_a + 16'(enter) - 16'(leave);
        sum_b = sum_b + sum_a - leave_weighted;
    endtask

    // Take one byte into the predicted state and work out the checksum transaction it causes.
    task automatic advance_window(input logic [7:0] value, input logic restart_flag,
                                  output t_checksum sums);
        int unsigned shift;
        int unsigned win_len;
        logic        two_windows;
        logic [7:0]  leave_newest;
        logic [7:0]  leave_prior;
        logic [15:0] mask_a;

        shift = (block_shift > MAX_BLOCK_SHIFT) ? MAX_BLOCK_SHIFT : block_shift;
        win_len = 1 << shift;
        two_windows = (window_count >= 2'd2);

        if (restart_flag) begin
            newest_a_sum = '0;
            newest_b_sum = '0;
            prior_a_sum = '0;
            prior_b_sum = '0;
            fill_level = 0;
        end

        leave_newest = history_byte(win_len);
        leave_prior = two_windows ? history_byte(2 * win_len) : 8'h00;
        roll_sums(newest_a_sum, newest_b_sum, value, leave_newest, shift);
        if (two_windows)
            roll_sums(prior_a_sum, prior_b_sum, leave_newest, leave_prior, shift);

        byte_log[log_slot] = value;
        log_slot = (log_slot + 1) % HISTORY_DEPTH;
        if (fill_level < FILL_LIMIT)
            fill_level++;

        if (sum_width < SUM_WIDTH_NARROW)
            mask_a = MASK_A_NONE;
        else if (sum_width == SUM_WIDTH_NARROW)
            mask_a = MASK_A_BYTE;
        else
            mask_a = MASK_A_FULL;

        sums.newest_a = newest_a_sum & mask_a;
        sums.newest_b = newest_b_sum;
        sums.prior_a = two_windows ? (prior_a_sum & mask_a) : 16'h0000;
        sums.prior_b = two_windows ? prior_b_sum : 16'h0000;
        sums.window_full = (fill_level >= (two_windows ? 2 * win_len : win_len));
    endtask

    // Results are compared before the byte of the same cycle is predicted.
    always @(posedge i_clk) begin
        t_checksum want;
        if (!i_rst_n) begin
            expected_sums.delete();
            log_slot = 0;
            fill_level = 0;
            newest_a_sum = '0;
            newest_b_sum = '0;
            prior_a_sum = '0;
            prior_b_sum = '0;
            block_shift = BLOCK_SHIFT_RST;
            window_count = WINDOW_COUNT_RST;
            sum_width = SUM_WIDTH_RST;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch($sformatf("checksum transaction with no byte pending: a=0x%04h b=0x%04h",
                                              i_newest_a, i_newest_b));
                end else begin
                    want = expected_sums.pop_front();
                    check_field("newest_a", i_newest_a, want.newest_a);
                    check_field("newest_b", i_newest_b, want.newest_b);
                    check_field("prior_a", i_prior_a, want.prior_a);
                    check_field("prior_b", i_prior_b, want.prior_b);
                    check_field("window_full", i_window_full, want.window_full);
                end
                results_seen++;
            end

            // Register writes; an unused index changes nothing.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BLOCK_SHIFT:  block_shift = i_cfg_data[3:0];
                    CFG_WINDOW_COUNT: window_count = i_cfg_data[1:0];
                    CFG_SUM_WIDTH:    sum_width = i_cfg_data[2:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                advance_window(i_data_byte, i_restart, want);
                expected_sums.push_back(want);
            end
        end
        o_pending <= expected_sums.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import rwc_pkg::*;

    localparam int MAX_BLOCK_SHIFT = 12;
    localparam int HISTORY_DEPTH   = 8192;
    localparam int SETTLE_CYCLES   = 4;
    localparam int LONG_HOLD       = 300;
    localparam int TIMEOUT_NS      = 1000000;
    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             in_data = 8'h00;
    logic                   in_restart = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [15:0]            newest_a;
    logic [15:0]            newest_b;
    logic [15:0]            prior_a;
    logic [15:0]            prior_b;
    logic                   window_full;

    int          fail_count;
    int          pending_sums;
    int          results_checked;
    int          send_idle_pct = 25;
    int          recv_idle_pct = 86;
    int          bytes_sent = 0;
    int          restarts_sent = 0;
    int          reg_writes = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    // Clock: 2 ns period.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    rolling_window_checksum #(
        .MAX_BLOCK_SHIFT (MAX_BLOCK_SHIFT),
        .HISTORY_DEPTH   (HISTORY_DEPTH)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_data_byte   (in_data),
        .i_restart     (in_restart),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_newest_a    (newest_a),
        .o_newest_b    (newest_b),
        .o_prior_a     (prior_a),
        .o_prior_b     (prior_b),
        .o_window_full (window_full)
    );

    rwc_checker #(
        .MAX_BLOCK_SHIFT (MAX_BLOCK_SHIFT),
        .HISTORY_DEPTH   (HISTORY_DEPTH)
    ) check_unit (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_data_byte   (in_data),
        .i_restart     (in_restart),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_newest_a    (newest_a),
        .i_newest_b    (newest_b),
        .i_prior_a     (prior_a),
        .i_prior_b     (prior_b),
        .i_window_full (window_full),
        .o_fail_count  (fail_count),
        .o_pending     (pending_sums),
        .o_checked     (results_checked)
    );

    // Receiver: random stalls, plus one long hold that lets the block back up.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_done <= 1'b1;
        end else if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Wait until every predicted checksum has come out, then let the pipeline settle.
    task automatic drain_results();
        do
            @(posedge clk);
        while (pending_sums != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write, only while no bytes are in flight.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] shift,
                                  input logic [CFG_DATA_W-1:0] seq,
                                  input logic [CFG_DATA_W-1:0] width);
        write_reg(CFG_BLOCK_SHIFT, shift);
        write_reg(CFG_WINDOW_COUNT, seq);
        write_reg(CFG_SUM_WIDTH, width);
    endtask

    // Mostly small windows so that they fill and roll; now and then larger, some beyond the largest.
    task automatic random_settings();
        logic [CFG_DATA_W-1:0] shift;
        shift = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(15, 6))
                                         : CFG_DATA_W'($urandom_range(4));
        write_settings(shift, CFG_DATA_W'($urandom_range(3)), CFG_DATA_W'($urandom_range(15)));
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(15)));
    endtask

    // Offer one byte and hold it until the block takes it. Valid is left high.
    task automatic send_byte(input logic [7:0] value, input logic restart_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= value;
        in_restart <= restart_flag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        if (restart_flag)
            restarts_sent++;
    endtask

    // Random bytes leaning on the extremes, with an occasional restart.
    task automatic stream_bytes(input int count, input logic allow_restart);
        logic [7:0] value;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(7))
                0:       value = 8'h00;
                1:       value = 8'hff;
                default: value = 8'($urandom_range(255));
            endcase
            send_byte(value, allow_restart && ($urandom_range(39) == 0));
        end
        in_valid <= 1'b0;
    endtask

    task automatic random_segment(input int count);
        random_settings();
        stream_bytes(count, 1'b1);
    endtask

    // Overall limit on the run.
    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d checksum transactions outstanding.", pending_sums);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte window, full mask, extremes of the byte.
        write_settings(4'd0, 4'd1, 4'd4);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        in_valid <= 1'b0;

        // Two windows of two bytes, byte mask on a.
        write_settings(4'd1, 4'd2, 4'd3);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hff, 1'b0);
        in_valid <= 1'b0;

        // Settings change mid-stream with no restart; a count of zero tracks one window
        // and a narrow width masks a away entirely.
        write_settings(4'd2, 4'd0, 4'd2);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hff, 1'b0);
        in_valid <= 1'b0;

        // Unused index is ignored; a count of three tracks two windows.
        write_reg(CFG_UNUSED, 4'hf);
        write_settings(4'd3, 4'd3, 4'd7);
        send_byte(8'hff, 1'b1);
        for (int n = 0; n < 4; n++)
            send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        in_valid <= 1'b0;

        // Random bytes, receiver mostly stalled.
        repeat (5) random_segment(30);

        // Sender mostly idle; the receiver holds off for a long stretch at the start.
        send_idle_pct = 86;
        recv_idle_pct = 25;
        random_settings();
        hold_req <= 1'b1;
        stream_bytes(50, 1'b1);
        repeat (4) random_segment(30);

        // Neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) random_segment(30);

        // Largest windows, two of them; in a short run they stay partly filled, so
        // the leaving bytes read as zero throughout.
        write_settings(4'd12, 4'd2, 4'd4);
        send_byte(8'($urandom_range(255)), 1'b1);
        stream_bytes(40, 1'b0);

        // A shift beyond the largest acts as the largest; roll on without restart, then with restarts allowed.
        write_settings(4'd15, 4'd1, 4'd1);
        stream_bytes(30, 1'b0);
        write_settings(4'd5, 4'd3, 4'd11);
        stream_bytes(20, 1'b1);

        drain_results();
        repeat (8) @(posedge clk);

        $display("Streamed %0d bytes (%0d restarts) with %0d register writes, window sizes 1 to 4096.",
                 bytes_sent, restarts_sent, reg_writes);
        $display("Compared %0d checksum transactions under random stalls and one long hold.",
                 results_checked);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[rolling_window_checksum.f]
hdl/rwc_pkg.sv
hdl/rolling_window_checksum.sv
verif/rwc_checker.sv
verif/tb.sv
